>>> design/rbes_pkg.sv
// Package: payload structs, command codes and a saturating add for the rigid body step.
package rbes_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned DT_W = 31;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_FORCE  = 2'd1,
		CMD_TORQUE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_SCALE = 2'd0,
		MODE_ADD   = 2'd1,
		MODE_SET   = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAV_EN  = 3'd0,
		REG_GRAV     = 3'd1,
		REG_INV_MASS = 3'd2,
		REG_LIN_DRAG = 3'd3,
		REG_ANG_DRAG = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [1:0]         apply_mode;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic [30:0]        time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] spin_x;
		logic signed [31:0] spin_y;
		logic signed [31:0] spin_z;
		logic               saturated;
	} out_item_t;

	// Saturate a 34-bit signed sum to 32 bits
	function automatic logic [32:0] clip_sum(input logic signed [33:0] s);
		logic [32:0] r;
		if (s > 34'sd2147483647)
			r = {1'b1, 32'h7FFF_FFFF};
		else if (s < -34'sd2147483648)
			r = {1'b1, 32'h8000_0000};
		else
			r = {1'b0, s[31:0]};
		return r;
	endfunction

endpackage

>>> design/rbes_isqrt.sv
// Bit-pair restoring integer square root of a 66-bit value, one result bit per cycle.
module rbes_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] radicand,
	output logic        done,
	output logic [32:0] root
);

	logic [65:0] rad_q;
	logic [34:0] rem_q;
	logic [32:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [34:0] trial;
	logic [34:0] rem_sh;

	// one result bit per cycle: shift in two radicand bits, try subtract
	assign rem_sh = {rem_q[32:0], rad_q[65:64]};
	assign trial  = rem_sh - {root_q[32:0], 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
				rem_q  <= '0;
				root_q <= '0;
				rad_q  <= radicand;
			end else if (busy_q) begin
				rad_q <= {rad_q[63:0], 2'b00};
				if (!trial[34]) begin
					rem_q  <= trial;
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[31:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign root = root_q;

endmodule

>>> design/rigid_body_euler_step.sv
// Top level: state registers, shared multiply-accumulate unit and sequencer of the rigid body step.
//  channel | direction | handshake            | payload
//  in      | request   | in_valid / in_ready  | in_item  (rbes_pkg::in_item_t)
//  out     | result    | out_valid / out_ready| out_item (rbes_pkg::out_item_t)
//  cfg     | write     | cfg_we               | cfg_idx, cfg_data
// Tick: two square roots and 19 products, each product split into a low and a high
// pass through the one 33x34 multiplier. Force/torque: one product per component.
// Unused command, or unused mode on force/torque: goes straight to the result.
// Reset clears the body state vectors and loads register defaults; no clearing pass.
// One request at a time; in_ready stays low until the result is taken, and out_ready
// low holds the result.
module rigid_body_euler_step #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  rbes_pkg::in_item_t                     in_item,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output rbes_pkg::out_item_t                    out_item,
	input  logic                                   cfg_we,
	input  logic [rbes_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [rbes_pkg::WORD_W-1:0]            cfg_data
);

	localparam logic signed [31:0] GRAV_RESET = -(32'sd10 <<< FRAC_BITS);
	localparam logic [30:0] Q_ONE31 = 31'(64'd1 << FRAC_BITS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_APPLY, ST_GRAV, ST_VADD, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT,
		ST_D1, ST_D2, ST_SCALE, ST_POS, ST_SPIN_ADD, ST_DONE
	} state_t;

	// config registers
	logic               grav_en_q;
	logic signed [31:0] grav_q;
	logic [30:0]        inv_mass_q, lin_drag_q, ang_drag_q;

	// state vectors
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] acc_q [3];
	logic signed [31:0] spn_q [3];
	logic signed [31:0] sacc_q [3];

	state_t             state_q;
	rbes_pkg::in_item_t req_q;
	logic [1:0]         idx_q;
	logic               ang_q;   // drag pass on spin
	logic               sat_q;
	logic [65:0]        sum_q;
	logic [63:0]        tmp_q;   // drag term chain
	logic signed [64:0] fac_q;   // drag factor
	logic               sq_start;
	logic               sq_done;
	logic [32:0]        sq_root;

	// shared multiplier operands
	logic signed [64:0]  mul_a;
	logic signed [33:0]  mul_b;
	logic signed [98:0]  mul_p;
	logic signed [32:0]  mul_x;    // low or high slice of mul_a
	logic signed [66:0]  mul_part;
	logic signed [66:0]  plo_q;    // low partial product
	logic                mh_q;     // high pass due
	logic                mul_wait;
	logic signed [31:0]  cur_v;
	logic signed [31:0]  vec_i;
	logic [32:0]         qm_res;  // {sat, value}
	logic signed [98:0]  qfl;

	rbes_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sum_q),
		.done(sq_done), .root(sq_root)
	);

	assign sq_start = (state_q == ST_SQRT_GO);

	always_comb begin
		cur_v = ang_q ? spn_q[idx_q] : vel_q[idx_q];
		case (idx_q)
			2'd0:    vec_i = req_q.vec_x;
			2'd1:    vec_i = req_q.vec_y;
			default: vec_i = req_q.vec_z;
		endcase
	end

	// operand select for the one multiplier
	always_comb begin
		mul_a = 65'sd0;
		mul_b = 34'sd0;
		unique case (state_q)
			ST_APPLY: begin
				mul_a = 65'(vec_i);
				mul_b = 34'($signed({1'b0, inv_mass_q}));
			end
			ST_SQ: begin
				mul_a = 65'(cur_v);
				mul_b = 34'(cur_v);
			end
			ST_D1: begin
				mul_a = $signed({1'b0, 32'd0, sq_root[31:0]});
				mul_b = 34'($signed({1'b0, (ang_q ? ang_drag_q : lin_drag_q)}));
			end
			ST_D2: begin
				mul_a = $signed({1'b0, tmp_q});
				mul_b = 34'($signed({1'b0, req_q.time_step}));
			end
			ST_SCALE: begin
				mul_a = fac_q;
				mul_b = 34'(cur_v);
			end
			ST_POS: begin
				mul_a = 65'(vel_q[idx_q]);
				mul_b = 34'($signed({1'b0, req_q.time_step}));
			end
			default: ;
		endcase
		// low 32 bits of mul_a on the first pass, the signed top on the second
		mul_x    = mh_q ? $signed(mul_a[64:32]) : $signed({1'b0, mul_a[31:0]});
		mul_part = 67'(mul_x) * 67'(mul_b);
		mul_p    = (99'(mul_part) <<< 32) + 99'(plo_q);
		mul_wait = !mh_q && (state_q inside {ST_APPLY, ST_SQ, ST_D1, ST_D2,
			ST_SCALE, ST_POS});
		// arithmetic shift is floor division
		qfl = mul_p >>> FRAC_BITS;
		if (qfl > 99'sd2147483647)
			qm_res = {1'b1, 32'h7FFF_FFFF};
		else if (qfl < -99'sd2147483648)
			qm_res = {1'b1, 32'h8000_0000};
		else
			qm_res = {1'b0, qfl[31:0]};
	end

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready   <= 1'b1;
			out_valid  <= 1'b0;
			grav_en_q  <= 1'b1;
			grav_q     <= GRAV_RESET;
			inv_mass_q <= Q_ONE31;
			lin_drag_q <= '0;
			ang_drag_q <= '0;
			idx_q      <= '0;
			ang_q      <= 1'b0;
			sat_q      <= 1'b0;
			mh_q       <= 1'b0;
			plo_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0; vel_q[i] <= '0; acc_q[i] <= '0;
				spn_q[i] <= '0; sacc_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					rbes_pkg::REG_GRAV_EN:  grav_en_q  <= cfg_data[0];
					rbes_pkg::REG_GRAV:     grav_q     <= $signed(cfg_data);
					rbes_pkg::REG_INV_MASS: inv_mass_q <= cfg_data[30:0];
					rbes_pkg::REG_LIN_DRAG: lin_drag_q <= cfg_data[30:0];
					rbes_pkg::REG_ANG_DRAG: ang_drag_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			// first pass of a product: hold the state, keep the low partial
			if (mul_wait) begin
				mh_q  <= 1'b1;
				plo_q <= mul_part;
			end else begin
				mh_q <= 1'b0;
				unique case (state_q)
					ST_IDLE: if (in_valid) begin
						req_q    <= in_item;
						in_ready <= 1'b0;
						sat_q    <= 1'b0;
						idx_q    <= '0;
						ang_q    <= (in_item.command == rbes_pkg::CMD_TORQUE);
						if (in_item.command == rbes_pkg::CMD_TICK)
							state_q <= ST_GRAV;
						else if ((in_item.command == rbes_pkg::CMD_FORCE ||
							in_item.command == rbes_pkg::CMD_TORQUE) &&
							(in_item.apply_mode inside {rbes_pkg::MODE_SCALE,
							rbes_pkg::MODE_ADD, rbes_pkg::MODE_SET}))
							state_q <= ST_APPLY;
						else
							state_q <= ST_DONE;
					end
					ST_APPLY: begin
						if (req_q.apply_mode == rbes_pkg::MODE_SET) begin
							if (ang_q) spn_q[idx_q] <= vec_i;
							else vel_q[idx_q] <= vec_i;
						end else begin
							logic signed [31:0] addend;
							logic signed [31:0] old;
							logic [32:0] s;
							addend = (req_q.apply_mode == rbes_pkg::MODE_SCALE) ?
								$signed(qm_res[31:0]) : vec_i;
							old = ang_q ? sacc_q[idx_q] : acc_q[idx_q];
							s = rbes_pkg::clip_sum(34'(old) + 34'(addend));
							if (req_q.apply_mode == rbes_pkg::MODE_SCALE && qm_res[32])
								sat_q <= 1'b1;
							if (s[32]) sat_q <= 1'b1;
							if (ang_q) sacc_q[idx_q] <= $signed(s[31:0]);
							else acc_q[idx_q] <= $signed(s[31:0]);
						end
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2) state_q <= ST_DONE;
					end
					ST_GRAV: begin
						if (grav_en_q) begin
							logic [32:0] s;
							s = rbes_pkg::clip_sum(34'(acc_q[1]) + 34'(grav_q));
							acc_q[1] <= $signed(s[31:0]);
							if (s[32]) sat_q <= 1'b1;
						end
						ang_q   <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_VADD;
					end
					ST_VADD, ST_SPIN_ADD: begin
						logic [32:0] s;
						s = ang_q ? rbes_pkg::clip_sum(34'(spn_q[idx_q]) + 34'(sacc_q[idx_q]))
							: rbes_pkg::clip_sum(34'(vel_q[idx_q]) + 34'(acc_q[idx_q]));
						if (ang_q) spn_q[idx_q] <= $signed(s[31:0]);
						else vel_q[idx_q] <= $signed(s[31:0]);
						if (s[32]) sat_q <= 1'b1;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_SQ;
						end
					end
					ST_SQ: begin
						sum_q <= sum_q + 66'(mul_p[63:0]);
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= ST_SQRT_GO;
						end
					end
					ST_SQRT_GO: state_q <= ST_SQRT_WAIT;
					ST_SQRT_WAIT: if (sq_done) state_q <= ST_D1;
					ST_D1: begin
						tmp_q   <= 64'(mul_p[97:0] >> FRAC_BITS);
						state_q <= ST_D2;
					end
					ST_D2: begin
						logic [97:0] d;
						d = mul_p[97:0] >> FRAC_BITS;
						if (d > (98'd1 << 56)) d = 98'd1 << 56;
						fac_q   <= (65'sd1 <<< FRAC_BITS) - $signed({8'd0, d[56:0]});
						state_q <= ST_SCALE;
					end
					ST_SCALE: begin
						if (ang_q) spn_q[idx_q] <= $signed(qm_res[31:0]);
						else vel_q[idx_q] <= $signed(qm_res[31:0]);
						if (qm_res[32]) sat_q <= 1'b1;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= ang_q ? ST_DONE : ST_POS;
						end
					end
					ST_POS: begin
						logic [32:0] s;
						s = rbes_pkg::clip_sum(34'(pos_q[idx_q]) + 34'($signed(qm_res[31:0])));
						pos_q[idx_q] <= $signed(s[31:0]);
						if (s[32] || qm_res[32]) sat_q <= 1'b1;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							ang_q   <= 1'b1;
							state_q <= ST_SPIN_ADD;
						end
					end
					ST_DONE: begin
						if (req_q.command == rbes_pkg::CMD_TICK && !out_valid) begin
							for (int i = 0; i < 3; i++) begin
								acc_q[i] <= '0; sacc_q[i] <= '0;
							end
						end
						if (!out_valid) out_valid <= 1'b1;
						else if (out_ready) begin
							out_valid <= 1'b0;
							in_ready  <= 1'b1;
							state_q   <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		out_item.pos_x     = pos_q[0];
		out_item.pos_y     = pos_q[1];
		out_item.pos_z     = pos_q[2];
		out_item.vel_x     = vel_q[0];
		out_item.vel_y     = vel_q[1];
		out_item.vel_z     = vel_q[2];
		out_item.spin_x    = spn_q[0];
		out_item.spin_y    = spn_q[1];
		out_item.spin_z    = spn_q[2];
		out_item.saturated = sat_q;
	end

	// ready and valid never both high
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// a taken request leaves idle
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready after request");
	// a root only completes while the sequencer waits for it
	a_sq: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQRT_WAIT) else $error("stray root");

endmodule

>>> sim/tb_top.sv
// Testbench for the rigid body step: directed table, random requests, scoreboard.
module tb_top;

	localparam int unsigned CLK_HALF   = 10;
	localparam int unsigned CYCLE_MAX  = 1000000;
	localparam int unsigned SETTLE     = 200;
	localparam int unsigned PHASE_REQS = 170;
	localparam logic [rbes_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [1:0] CMD_SPARE  = 2'd3;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_t;

	typedef struct {
		rbes_pkg::in_item_t  req;
		bit                  typed;
		rbes_pkg::out_item_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rbes_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rbes_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [rbes_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [rbes_pkg::WORD_W-1:0] cfg_data = '0;

	// predictor copy of state and registers
	logic signed [31:0] m_pos [3];
	logic signed [31:0] m_vel [3];
	logic signed [31:0] m_acc [3];
	logic signed [31:0] m_spin [3];
	logic signed [31:0] m_spin_acc [3];
	bit m_grav_en;
	logic signed [31:0] m_grav;
	logic [30:0] m_inv_mass, m_lin_drag, m_ang_drag;

	rbes_pkg::out_item_t state_due [$];
	int errors = 0;
	int cycles = 0;
	idle_t idle_mode = IDLE_NONE;
	row_t rows [$];

	rigid_body_euler_step u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// fixed-point helpers
	function automatic logic signed [31:0] clip32(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qmul(input logic signed [63:0] a,
			input logic signed [63:0] b, inout bit sat);
		logic signed [127:0] p;
		logic signed [127:0] q;
		p = a * b;
		q = p >>> 16;
		if (q > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (q < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return q[31:0];
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// v *= 1 - drag*|v|*dt, with the drag term capped at 2^56
	function automatic void apply_drag(inout logic signed [31:0] v [3],
			input logic [30:0] drag, input logic [30:0] dt, inout bit sat);
		longint unsigned sum, len, t1, d, mag;
		logic [127:0] prod;
		logic signed [63:0] f;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag = v[i] < 0 ? 64'(-longint'(v[i])) : 64'(v[i]);
			sum += mag * mag;
		end
		len = root_floor(sum);
		t1 = (64'(drag) * len) >> 16;
		prod = 128'(t1) * 128'(dt);
		if (prod[127:64] != 0)
			d = 64'd1 << 56;
		else
			d = prod[79:16];
		if (d > (64'd1 << 56))
			d = 64'd1 << 56;
		f = 64'sd65536 - $signed(d);
		for (int i = 0; i < 3; i++)
			v[i] = qmul(64'(v[i]), f, sat);
	endfunction

	function automatic void gather(input rbes_pkg::in_item_t r,
			inout logic signed [31:0] acc [3],
			inout logic signed [31:0] vel [3], inout bit sat);
		logic signed [31:0] vec [3];
		vec[0] = r.vec_x;
		vec[1] = r.vec_y;
		vec[2] = r.vec_z;
		for (int i = 0; i < 3; i++) begin
			case (r.apply_mode)
				rbes_pkg::MODE_SCALE: acc[i] = clip32(longint'(acc[i]) +
						qmul(64'(vec[i]), 64'(m_inv_mass), sat), sat);
				rbes_pkg::MODE_ADD: acc[i] = clip32(longint'(acc[i]) + vec[i], sat);
				rbes_pkg::MODE_SET: vel[i] = vec[i];
				default: ;
			endcase
		end
	endfunction

	// advance the predictor by one request and return the state it reports
	function automatic rbes_pkg::out_item_t body_step(input rbes_pkg::in_item_t r);
		rbes_pkg::out_item_t o;
		bit sat;
		sat = 1'b0;
		case (r.command)
			rbes_pkg::CMD_TICK: begin
				if (m_grav_en)
					m_acc[1] = clip32(longint'(m_acc[1]) + m_grav, sat);
				for (int i = 0; i < 3; i++)
					m_vel[i] = clip32(longint'(m_vel[i]) + m_acc[i], sat);
				apply_drag(m_vel, m_lin_drag, r.time_step, sat);
				for (int i = 0; i < 3; i++)
					m_pos[i] = clip32(longint'(m_pos[i]) +
							qmul(64'(m_vel[i]), 64'(r.time_step), sat), sat);
				for (int i = 0; i < 3; i++)
					m_spin[i] = clip32(longint'(m_spin[i]) + m_spin_acc[i], sat);
				apply_drag(m_spin, m_ang_drag, r.time_step, sat);
				for (int i = 0; i < 3; i++) begin
					m_acc[i] = '0;
					m_spin_acc[i] = '0;
				end
			end
			rbes_pkg::CMD_FORCE: gather(r, m_acc, m_vel, sat);
			rbes_pkg::CMD_TORQUE: gather(r, m_spin_acc, m_spin, sat);
			default: ;
		endcase
		o.pos_x = m_pos[0];
		o.pos_y = m_pos[1];
		o.pos_z = m_pos[2];
		o.vel_x = m_vel[0];
		o.vel_y = m_vel[1];
		o.vel_z = m_vel[2];
		o.spin_x = m_spin[0];
		o.spin_y = m_spin[1];
		o.spin_z = m_spin[2];
		o.saturated = sat;
		return o;
	endfunction

	function automatic rbes_pkg::in_item_t make_req(input logic [1:0] cmd,
			input logic [1:0] mode,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [30:0] dt);
		rbes_pkg::in_item_t r;
		r.command = cmd;
		r.apply_mode = mode;
		r.vec_x = x;
		r.vec_y = y;
		r.vec_z = z;
		r.time_step = dt;
		return r;
	endfunction

	function automatic logic [31:0] rand_comp();
		int unsigned span;
		if ($urandom_range(99) < 15)
			return $urandom;
		span = 1 << $urandom_range(4, 22);
		return 32'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic rbes_pkg::in_item_t rand_req();
		rbes_pkg::in_item_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			r.command = rbes_pkg::CMD_TICK;
		else if (pick < 75)
			r.command = rbes_pkg::CMD_FORCE;
		else if (pick < 95)
			r.command = rbes_pkg::CMD_TORQUE;
		else
			r.command = CMD_SPARE;
		r.apply_mode = ($urandom_range(99) < 5) ? MODE_SPARE : 2'($urandom_range(2));
		r.vec_x = rand_comp();
		r.vec_y = rand_comp();
		r.vec_z = rand_comp();
		r.time_step = ($urandom_range(99) < 10) ? 31'($urandom) : 31'($urandom_range(16384));
		return r;
	endfunction

	task automatic write_reg(input logic [rbes_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			rbes_pkg::REG_GRAV_EN: m_grav_en = data[0];
			rbes_pkg::REG_GRAV: m_grav = data;
			rbes_pkg::REG_INV_MASS: m_inv_mass = data[30:0];
			rbes_pkg::REG_LIN_DRAG: m_lin_drag = data[30:0];
			rbes_pkg::REG_ANG_DRAG: m_ang_drag = data[30:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_body(input logic [31:0] en, input logic [31:0] grav,
			input logic [31:0] inv_mass, input logic [31:0] lin, input logic [31:0] ang);
		write_reg(rbes_pkg::REG_GRAV_EN, en);
		write_reg(rbes_pkg::REG_GRAV, grav);
		write_reg(rbes_pkg::REG_INV_MASS, inv_mass);
		write_reg(rbes_pkg::REG_LIN_DRAG, lin);
		write_reg(rbes_pkg::REG_ANG_DRAG, ang);
	endtask

	// hold the request until taken; optional idle gap first
	task automatic send_req(input rbes_pkg::in_item_t r, input bit typed,
			input rbes_pkg::out_item_t want);
		int unsigned pct, gap;
		rbes_pkg::out_item_t pred;
		pct = (idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH) ? 34 : 0;
		gap = 0;
		while ($urandom_range(99) < pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= r;
		do @(posedge clk); while (!in_ready);
		pred = body_step(r);
		state_due.push_back(typed ? want : pred);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (state_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver stalls
	always @(posedge clk) begin
		int unsigned pct;
		pct = (idle_mode == IDLE_RECV) ? 51 : (idle_mode == IDLE_BOTH) ? 34 : 0;
		out_ready <= ($urandom_range(99) >= pct);
	end

	task automatic check_word(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
			errors++;
		end
	endtask

	// compare every taken result with the oldest expected state
	always @(posedge clk) begin
		rbes_pkg::out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (state_due.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $realtime, out_item);
				errors++;
			end else begin
				w = state_due.pop_front();
				check_word("pos_x", w.pos_x, out_item.pos_x);
				check_word("pos_y", w.pos_y, out_item.pos_y);
				check_word("pos_z", w.pos_z, out_item.pos_z);
				check_word("vel_x", w.vel_x, out_item.vel_x);
				check_word("vel_y", w.vel_y, out_item.vel_y);
				check_word("vel_z", w.vel_z, out_item.vel_z);
				check_word("spin_x", w.spin_x, out_item.spin_x);
				check_word("spin_y", w.spin_y, out_item.spin_y);
				check_word("spin_z", w.spin_z, out_item.spin_z);
				check_word("saturated", 32'(w.saturated), 32'(out_item.saturated));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic add_row(input rbes_pkg::in_item_t r, input bit typed,
			input rbes_pkg::out_item_t want);
		row_t e;
		e.req = r;
		e.typed = typed;
		e.want = want;
		rows.push_back(e);
	endtask

	initial begin
		rbes_pkg::out_item_t w;
		logic [31:0] qmax, qmin;
		qmax = 32'h7FFF_FFFF;
		qmin = 32'h8000_0000;
		for (int i = 0; i < 3; i++) begin
			m_pos[i] = '0;
			m_vel[i] = '0;
			m_acc[i] = '0;
			m_spin[i] = '0;
			m_spin_acc[i] = '0;
		end
		m_grav_en = 1'b1;
		m_grav = -32'sd655360;
		m_inv_mass = 31'd65536;
		m_lin_drag = '0;
		m_ang_drag = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: reset defaults, extremes, spare codes
		w = '0;
		w.vel_y = -32'sd655360;
		add_row(make_req(rbes_pkg::CMD_TICK, rbes_pkg::MODE_SCALE, 0, 0, 0, 0), 1'b1, w);
		w.vel_x = 32'sd65536;
		w.vel_y = 32'sd131072;
		w.vel_z = 32'sd196608;
		add_row(make_req(rbes_pkg::CMD_FORCE, rbes_pkg::MODE_SET, 32'd65536, 32'd131072,
				32'd196608, 0), 1'b1, w);
		add_row(make_req(rbes_pkg::CMD_FORCE, rbes_pkg::MODE_ADD, qmax, 0, 0, 0), 1'b1, w);
		w.saturated = 1'b1;
		add_row(make_req(rbes_pkg::CMD_FORCE, rbes_pkg::MODE_ADD, qmax, 0, 0, 0), 1'b1, w);
		add_row(make_req(rbes_pkg::CMD_FORCE, rbes_pkg::MODE_SCALE, qmin, qmin, qmin,
				31'h7FFF_FFFF), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TICK, rbes_pkg::MODE_SCALE, 0, 0, 0, 31'd65536),
				1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TORQUE, rbes_pkg::MODE_SET, qmax, qmin,
				32'hFFFF_FFFF, 0), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TORQUE, rbes_pkg::MODE_ADD, qmin, qmax, 32'd1, 0),
				1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TORQUE, rbes_pkg::MODE_SCALE, qmax, qmax, qmin, 0),
				1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TICK, rbes_pkg::MODE_ADD, 0, 0, 0, 31'h7FFF_FFFF),
				1'b0, w);
		add_row(make_req(CMD_SPARE, rbes_pkg::MODE_ADD, qmax, qmax, qmax, 31'd100), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_FORCE, MODE_SPARE, qmax, qmax, qmax, 0), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TORQUE, MODE_SPARE, qmin, qmin, qmin, 0), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_FORCE, rbes_pkg::MODE_SET, 0, 0, 0, 0), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TORQUE, rbes_pkg::MODE_SET, 32'd4096, 0,
				32'hFFFF_0000, 0), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TICK, rbes_pkg::MODE_SET, 0, 0, 0, 31'd1), 1'b0, w);
		add_row(make_req(rbes_pkg::CMD_TICK, rbes_pkg::MODE_SET, 0, 0, 0, 31'd6553), 1'b0, w);
		foreach (rows[i])
			send_req(rows[i].req, rows[i].typed, rows[i].want);
		drain();

		// random phases, each with its own register setting; idling cycles through the idle modes
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_body(1, -32'sd655360, 32'd65536, 0, 0);
				1: set_body(0, qmin, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				2: set_body(1, qmax, 32'h7FFF_FFFF, 32'd64, 32'd16);
				3: set_body(1, qmin, 32'd32768, 32'd655, 32'd1000);
				default: set_body($urandom, $urandom, $urandom, $urandom_range(4096),
						$urandom_range(4096));
			endcase
			if (ph == 0)
				write_reg(REG_SPARE, 32'hFFFF_FFFF);
			idle_mode = idle_t'(ph % 4);
			for (int n = 0; n < PHASE_REQS; n++)
				send_req(rand_req(), 1'b0, '0);
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> rigid_body_euler_step.f
design/rbes_pkg.sv
design/rbes_isqrt.sv
design/rigid_body_euler_step.sv
sim/tb_top.sv
